// ===== rtl/pcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcr_pkg;

  localparam int ADC_BITS   = 10;
  localparam int CORR_LIMIT = 30;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = 50;
  localparam int CORR_W     = 24;
  localparam int CARRY_W    = 17;
  localparam int DELAY_W    = 16;
  localparam int CORR_OUT_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;
  localparam int IN_USER_W  = 2;

  localparam logic signed [63:0] SAT32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_THRESHOLD   = 3'd3,
    REG_SETPOINT    = 3'd4,
    REG_CAL_AMPS    = 3'd5,
    REG_CAL_ADC     = 3'd6,
    REG_SLOPE       = 3'd7
  } reg_idx_t;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_MUL_AMPS = 15'b000000000000010,
    ST_AMPS     = 15'b000000000000100,
    ST_ERR      = 15'b000000000001000,
    ST_INTEG    = 15'b000000000010000,
    ST_DERIV    = 15'b000000000100000,
    ST_MUL_P    = 15'b000000001000000,
    ST_ACC_P    = 15'b000000010000000,
    ST_MUL_I    = 15'b000000100000000,
    ST_ACC_I    = 15'b000001000000000,
    ST_MUL_D    = 15'b000010000000000,
    ST_ACC_D    = 15'b000100000000000,
    ST_CLAMP    = 15'b001000000000000,
    ST_CORR     = 15'b010000000000000,
    ST_DONE     = 15'b100000000000000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pid_current_regulator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PID current regulator with conditional integration. Each input word carries an
// ADC reading and the present triac delay; a sample word (func 0) returns the
// updated delay, the integer correction, the calibrated current and the
// integration flag, while clear (1) and restart (2) words reset the loop state
// and echo the delay. A sample passes through the sequencer, which runs the
// calibration and the three gain products through one shared 32x32 multiplier,
// before it reaches the result register; a clear or restart word goes straight
// to it. A new word is taken only once the last one is in the output register.
// Input is taken only while the sequencer is idle; a finished result waits in
// the output register without holding the input back. Gains, setpoint and
// calibration are Q16.16 and are to be written through the cfg port only while
// no word is in flight; the block itself does not enforce this.
module pid_current_regulator_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [pcr_pkg::IN_DATA_W-1:0]     s_tdata,   // adc_sample, current_delay
  input  wire  [pcr_pkg::IN_USER_W-1:0]     s_tuser,   // func
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [pcr_pkg::OUT_DATA_W-1:0]    m_tdata,   // new_delay, correction,
                                                       // measured_amps, integrating
  input  wire                               cfg_en,
  input  wire  [pcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pcr_pkg::*;

  localparam logic signed [ACC_W-1:0] CORR_MAX = ACC_W'(CORR_LIMIT) <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] CORR_MIN = -CORR_MAX;

  logic signed [31:0]          gain_p, gain_i, gain_d;
  logic        [30:0]          error_threshold;
  logic signed [31:0]          setpoint_amps, cal_low_amps, amps_per_count;
  logic        [ADC_BITS-1:0]  cal_low_adc;

  logic signed [31:0]          error_integral, previous_error;
  logic                        has_started;
  logic signed [CARRY_W-1:0]   carry_fraction;

  state_t                      state;
  logic        [ADC_BITS-1:0]  adc;
  logic signed [DELAY_W-1:0]   delay_in;
  logic signed [31:0]          amps, err, deriv;
  logic signed [63:0]          prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [CORR_W-1:0]    clamped;

  logic signed [DELAY_W-1:0]   res_delay;
  logic signed [CORR_OUT_W-1:0] res_corr;
  logic signed [31:0]          res_amps;
  logic                        res_integ;

  logic signed [ADC_BITS:0]    adc_diff;
  logic signed [31:0]          mul_a, mul_b;
  logic signed [63:0]          amps_sum;
  logic signed [32:0]          err_diff, int_sum, der_diff;
  logic        [32:0]          err_abs;
  logic                        integ_hit;
  logic signed [ACC_W-1:0]     term;
  logic signed [ACC_W-1:0]     acc_clamped;
  logic signed [CORR_W-1:0]    corr;
  logic                        corr_round;
  logic signed [CORR_W-FRAC_BITS-1:0] corr_int;
  logic signed [DELAY_W:0]     delay_sum;
  logic signed [DELAY_W-1:0]   delay_sat;
  logic                        in_fire, out_free;
  func_t                       in_func;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_func  = func_t'(s_tuser[1:0]);

  assign adc_diff = $signed({1'b0, adc}) - $signed({1'b0, cal_low_adc});

  always_comb begin
    case (state)
      ST_MUL_AMPS: begin
        mul_a = amps_per_count;
        mul_b = {{(32-ADC_BITS-1){adc_diff[ADC_BITS]}}, adc_diff};
      end
      ST_MUL_P: begin
        mul_a = gain_p;
        mul_b = err;
      end
      ST_MUL_I: begin
        mul_a = gain_i;
        mul_b = error_integral;
      end
      ST_MUL_D: begin
        mul_a = gain_d;
        mul_b = deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign amps_sum  = {{32{cal_low_amps[31]}}, cal_low_amps} + prod;
  assign err_diff  = {amps[31], amps} - {setpoint_amps[31], setpoint_amps};
  assign err_abs   = err[31] ? 33'(-{err[31], err}) : {err[31], err};
  assign integ_hit = err_abs < {2'b00, error_threshold};
  assign int_sum   = {error_integral[31], error_integral} + {err[31], err};
  assign der_diff  = {err[31], err} - {previous_error[31], previous_error};
  assign term      = {{(ACC_W-48){prod[63]}}, prod[63:FRAC_BITS]};

  always_comb begin
    if (acc > CORR_MAX) begin
      acc_clamped = CORR_MAX;
    end else if (acc < CORR_MIN) begin
      acc_clamped = CORR_MIN;
    end else begin
      acc_clamped = acc;
    end
  end

  assign corr       = clamped + {{(CORR_W-CARRY_W){carry_fraction[CARRY_W-1]}}, carry_fraction};
  assign corr_round = corr[CORR_W-1] && (|corr[FRAC_BITS-1:0]);
  assign corr_int   = corr[CORR_W-1:FRAC_BITS]
                    + {{(CORR_W-FRAC_BITS-1){1'b0}}, corr_round};
  assign delay_sum  = {delay_in[DELAY_W-1], delay_in}
                    + {{(DELAY_W+1-(CORR_W-FRAC_BITS)){corr_int[CORR_W-FRAC_BITS-1]}},
                       corr_int};

  always_comb begin
    if (delay_sum[DELAY_W] != delay_sum[DELAY_W-1]) begin
      delay_sat = delay_sum[DELAY_W] ? {1'b1, {(DELAY_W-1){1'b0}}}
                                     : {1'b0, {(DELAY_W-1){1'b1}}};
    end else begin
      delay_sat = delay_sum[DELAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      gain_p          <= -32'sd32440;
      gain_i          <= '0;
      gain_d          <= '0;
      error_threshold <= 31'd327680;
      setpoint_amps   <= '0;
      cal_low_amps    <= '0;
      cal_low_adc     <= '0;
      amps_per_count  <= '0;
      error_integral  <= '0;
      previous_error  <= '0;
      has_started     <= 1'b0;
      carry_fraction  <= '0;
    end else begin
      if (cfg_en) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P:    gain_p          <= cfg_data;
          REG_GAIN_I:    gain_i          <= cfg_data;
          REG_GAIN_D:    gain_d          <= cfg_data;
          REG_THRESHOLD: error_threshold <= cfg_data[30:0];
          REG_SETPOINT:  setpoint_amps   <= cfg_data;
          REG_CAL_AMPS:  cal_low_amps    <= cfg_data;
          REG_CAL_ADC:   cal_low_adc     <= cfg_data[ADC_BITS-1:0];
          REG_SLOPE:     amps_per_count  <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            adc       <= s_tdata[ADC_BITS-1:0];
            delay_in  <= s_tdata[ADC_BITS +: DELAY_W];
            res_delay <= s_tdata[ADC_BITS +: DELAY_W];
            res_corr  <= '0;
            res_amps  <= '0;
            res_integ <= 1'b0;
            case (in_func)
              FUNC_SAMPLE: begin
                state <= ST_MUL_AMPS;
              end
              FUNC_CLEAR, FUNC_RESTART: begin
                error_integral <= '0;
                previous_error <= '0;
                carry_fraction <= '0;
                if (in_func == FUNC_RESTART) begin
                  has_started <= 1'b0;
                end
                state <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_MUL_AMPS: begin
          prod  <= mul_a * mul_b;
          state <= ST_AMPS;
        end
        ST_AMPS: begin
          amps  <= sat32(amps_sum);
          state <= ST_ERR;
        end
        ST_ERR: begin
          err      <= sat32({{31{err_diff[32]}}, err_diff});
          res_amps <= amps;
          state    <= ST_INTEG;
        end
        ST_INTEG: begin
          res_integ <= integ_hit;
          if (integ_hit) begin
            error_integral <= sat32({{31{int_sum[32]}}, int_sum});
          end else begin
            error_integral <= '0;
          end
          state <= ST_DERIV;
        end
        ST_DERIV: begin
          if (has_started) begin
            deriv <= sat32({{31{der_diff[32]}}, der_diff});
          end else begin
            deriv <= '0;
          end
          has_started    <= 1'b1;
          previous_error <= err;
          state          <= ST_MUL_P;
        end
        ST_MUL_P: begin
          prod  <= mul_a * mul_b;
          state <= ST_ACC_P;
        end
        ST_ACC_P: begin
          acc   <= term;
          state <= ST_MUL_I;
        end
        ST_MUL_I: begin
          prod  <= mul_a * mul_b;
          state <= ST_ACC_I;
        end
        ST_ACC_I: begin
          acc   <= acc + term;
          state <= ST_MUL_D;
        end
        ST_MUL_D: begin
          prod  <= mul_a * mul_b;
          state <= ST_ACC_D;
        end
        ST_ACC_D: begin
          acc   <= acc + term;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          clamped <= acc_clamped[CORR_W-1:0];
          state   <= ST_CORR;
        end
        ST_CORR: begin
          carry_fraction <= {corr_round, corr[FRAC_BITS-1:0]};
          res_corr       <= corr_int[CORR_OUT_W-1:0];
          res_delay      <= delay_sat;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata  <= {1'b0, res_integ, res_amps, res_corr, res_delay};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_func == FUNC_SAMPLE) |=> state == ST_MUL_AMPS)
    else $error("sample word did not start the sequencer");

  a_other_done: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_func != FUNC_SAMPLE) |=> state == ST_DONE)
    else $error("non-sample word did not go straight to result");

  a_carry_range: assert property (@(posedge clk) disable iff (rst)
    carry_fraction != {1'b1, {(CARRY_W-1){1'b0}}})
    else $error("carried fraction reached one");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> m_tvalid && (state == ST_IDLE))
    else $error("result not loaded into output register");

  a_started_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(has_started) |-> $past(state == ST_DERIV))
    else $error("has_started set outside a sample");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pcr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam longint Q_ONE = 65536;

  typedef struct {
    logic signed [15:0] new_delay;
    logic signed [5:0]  correction;
    logic signed [31:0] amps;
    logic               integ;
  } loop_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // adc_sample, current_delay
  logic [IN_USER_W-1:0]  s_tuser = '0;   // func
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] m_tdata;        // new_delay, correction, measured_amps, integrating
  logic                  cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wire signed [15:0] out_delay = m_tdata[15:0];
  wire signed [5:0]  out_corr  = m_tdata[21:16];
  wire signed [31:0] out_amps  = m_tdata[53:22];
  wire               out_integ = m_tdata[54];

  pid_current_regulator_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // loop settings and state as the block should hold them
  logic signed [31:0] kp, ki, kd, sp_amps, cal_amps, slope;
  logic [30:0]        thresh;
  logic [9:0]         cal_adc;
  longint             integral, prev_err, carry;
  bit                 started;

  loop_result_t pending_results[$];
  loop_result_t head;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int fails = 0;
  int mismatches = 0;
  int cycles = 0;
  int n_items = 0, n_sample = 0, n_integ = 0, n_clamped = 0, n_sat_delay = 0;
  int n_clear = 0, n_restart = 0, n_unused = 0, n_settings = 0;
  int adc_center = 512;
  int adc_spread = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic loop_result_t regulate(func_t f, logic [9:0] adc,
                                            logic signed [15:0] delay);
    loop_result_t r;
    longint amps, err, mag, deriv, sum, lim, corr, cint, moved;
    r.new_delay = delay;
    r.correction = '0;
    r.amps = '0;
    r.integ = 1'b0;
    case (f)
      FUNC_SAMPLE: begin
        amps = clip32(longint'(cal_amps) + longint'(slope) * (longint'(adc) - longint'(cal_adc)));
        err = clip32(amps - longint'(sp_amps));
        mag = (err < 0) ? -err : err;
        if (mag < longint'(thresh)) begin
          r.integ = 1'b1;
          integral = clip32(integral + err);
        end else begin
          integral = 0;
        end
        if (!started) begin
          started = 1'b1;
          deriv = 0;
        end else begin
          deriv = clip32(err - prev_err);
        end
        prev_err = err;
        sum = ((longint'(kp) * err) >>> 16) + ((longint'(ki) * integral) >>> 16)
            + ((longint'(kd) * deriv) >>> 16);
        lim = longint'(CORR_LIMIT) * Q_ONE;
        if (sum > lim || sum < -lim) n_clamped++;
        sum = clip(sum, -lim, lim);
        corr = sum + carry;
        cint = corr / Q_ONE;
        carry = corr - cint * Q_ONE;
        moved = longint'(delay) + cint;
        if (moved > 32767 || moved < -32768) n_sat_delay++;
        r.new_delay = 16'(clip(moved, -32768, 32767));
        r.correction = 6'(cint);
        r.amps = 32'(amps);
        n_sample++;
        if (r.integ) n_integ++;
      end
      FUNC_CLEAR, FUNC_RESTART: begin
        integral = 0;
        prev_err = 0;
        carry = 0;
        if (f == FUNC_RESTART) begin
          started = 1'b0;
          n_restart++;
        end else begin
          n_clear++;
        end
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:    kp = data;
      REG_GAIN_I:    ki = data;
      REG_GAIN_D:    kd = data;
      REG_THRESHOLD: thresh = data[30:0];
      REG_SETPOINT:  sp_amps = data;
      REG_CAL_AMPS:  cal_amps = data;
      REG_CAL_ADC:   cal_adc = data[9:0];
      REG_SLOPE:     slope = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] p, i, d, th, sp, ca, cadc, sl);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_CAL_AMPS, ca);
    write_reg(REG_CAL_ADC, cadc);
    write_reg(REG_SLOPE, sl);
    cfg_en <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic send_word(func_t f, logic [9:0] adc, logic signed [15:0] delay);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, delay, adc};
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(regulate(f, adc, delay));
    n_items++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fails++;
        $display("unexpected word: delay %0d corr %0d amps %0d integ %0d",
                 out_delay, out_corr, out_amps, out_integ);
      end else begin
        head = pending_results.pop_front();
        if (head.new_delay !== out_delay || head.correction !== out_corr ||
            head.amps !== out_amps || head.integ !== out_integ) begin
          fails++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch (exp/got): delay %0d/%0d corr %0d/%0d amps %0d/%0d integ %0d/%0d",
                     head.new_delay, out_delay, head.correction, out_corr,
                     head.amps, out_amps, head.integ, out_integ);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_extreme();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h0;
      3: v = 32'h1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic randomize_setting(int mode);
    int sl, cadc;
    logic [31:0] ca, sp;
    case (mode)
      0: begin
        sl = $urandom_range(300, 20000);
        if ($urandom_range(0, 1)) sl = -sl;
        cadc = $urandom_range(0, 1023);
        ca = int'($urandom_range(0, 4194304)) - 2097152;
        adc_center = $urandom_range(0, 1023);
        adc_spread = $urandom_range(2, 24);
        sp = 32'(clip32(longint'(signed'(ca)) + longint'(sl) * (adc_center - cadc)
                        + int'($urandom_range(0, 4000)) - 2000));
        set_regs(int'($urandom_range(0, 524288)) - 262144,
                 int'($urandom_range(0, 131072)) - 65536,
                 int'($urandom_range(0, 262144)) - 131072,
                 $urandom_range(16384, 2097152), sp, ca,
                 ($urandom & 32'hFFFF_FC00) | cadc, sl);
      end
      1: begin
        adc_spread = 0;
        set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      end
      default: begin
        adc_spread = 0;
        set_regs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end
    endcase
  endtask

  task automatic send_random_word();
    func_t f;
    int pick, a;
    logic signed [15:0] delay;
    pick = $urandom_range(0, 99);
    if (pick < 85) f = FUNC_SAMPLE;
    else if (pick < 90) f = FUNC_CLEAR;
    else if (pick < 95) f = FUNC_RESTART;
    else f = FUNC_UNUSED;
    if (adc_spread == 0 || $urandom_range(0, 9) < 3) begin
      a = $urandom_range(0, 1023);
    end else begin
      a = int'(clip(adc_center + int'($urandom_range(0, 2 * adc_spread)) - adc_spread,
                    0, 1023));
    end
    if ($urandom_range(0, 9) == 0)
      delay = $urandom_range(0, 1) ? 16'(16'sh7FFF - $urandom_range(0, 40))
                                   : 16'(16'sh8000 + $urandom_range(0, 40));
    else
      delay = 16'($urandom);
    send_word(f, 10'(a), delay);
  endtask

  task automatic test_reset_defaults();
    send_word(FUNC_SAMPLE, 10'd0, 16'sd0);
    send_word(FUNC_SAMPLE, 10'd1023, -16'sd100);
  endtask

  task automatic test_threshold_and_clamp();
    drain();
    set_regs(-32'sd29491, 32'sd72090, 32'sd327680, 32'd5 << 16, 32'd0, 32'd0, 32'd0,
             32'sd65536);
    send_word(FUNC_SAMPLE, 10'd4, 16'sd100);
    send_word(FUNC_SAMPLE, 10'd5, 16'sd100);
    send_word(FUNC_SAMPLE, 10'd3, 16'sd100);
    send_word(FUNC_SAMPLE, 10'd2, 16'sd100);
    send_word(FUNC_SAMPLE, 10'd1023, -16'sd32760);
    send_word(FUNC_SAMPLE, 10'd0, 16'sd32760);
  endtask

  task automatic test_clear_restart();
    drain();
    set_regs(32'sd45875, 32'sd72090, -32'sd29491, 32'd5 << 16, 32'd2 << 16, 32'd0,
             32'd0, 32'sd65536);
    send_word(FUNC_SAMPLE, 10'd3, 16'sd500);
    send_word(FUNC_SAMPLE, 10'd1, 16'sd500);
    send_word(FUNC_CLEAR, 10'd1023, 16'sd1234);
    send_word(FUNC_SAMPLE, 10'd3, 16'sd500);
    send_word(FUNC_RESTART, 10'd512, -16'sd1);
    send_word(FUNC_SAMPLE, 10'd2, 16'sd500);
    send_word(FUNC_UNUSED, 10'd7, 16'sh5A5A);
    send_word(FUNC_SAMPLE, 10'd1, 16'sd500);
  endtask

  task automatic test_saturation();
    drain();
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd0,
             32'd0, 32'h7FFF_FFFF);
    send_word(FUNC_SAMPLE, 10'd1, 16'sh7FFF);
    send_word(FUNC_SAMPLE, 10'd1, 16'sh7FFF);
    send_word(FUNC_SAMPLE, 10'd0, -16'sh8000);
    send_word(FUNC_SAMPLE, 10'd1023, 16'sd0);
    drain();
    set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF,
             32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    send_word(FUNC_SAMPLE, 10'd0, 16'sd0);
    send_word(FUNC_SAMPLE, 10'd1023, 16'sh7FFF);
    send_word(FUNC_SAMPLE, 10'd512, -16'sh8000);
  endtask

  task automatic test_random_traffic(int src_pct, int snk_pct, int n);
    int k;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (k = 0; k < n; k++) begin
      if (k % 25 == 0) begin
        drain();
        randomize_setting((k / 25 == 2) ? 1 : ((k / 25 == 4) ? 2 : 0));
      end
      send_random_word();
    end
  endtask

  initial begin
    kp = -32'sd32440;
    ki = '0;
    kd = '0;
    thresh = 31'd327680;
    sp_amps = '0;
    cal_amps = '0;
    cal_adc = '0;
    slope = '0;
    integral = 0;
    prev_err = 0;
    carry = 0;
    started = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_and_clamp();
    test_clear_restart();
    test_saturation();
    test_random_traffic(0, 0, 125);
    test_random_traffic(86, 0, 125);
    test_random_traffic(0, 86, 125);
    test_random_traffic(33, 33, 125);
    drain();
    fails += pending_results.size();
    $display("%0d words over %0d register settings: %0d samples (%0d integrating, %0d clamped,",
             n_items, n_settings, n_sample, n_integ, n_clamped);
    $display("  %0d delay saturations), %0d clears, %0d restarts, %0d unused codes; %0d errors",
             n_sat_delay, n_clear, n_restart, n_unused, fails);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== pid_current_regulator_top.f =====
rtl/pcr_pkg.sv
rtl/pid_current_regulator_top.sv
test/testbench.sv
